FILE: hw/rtl/u8dn_pkg.sv
package u8dn_pkg;

    // Width of the scalar counter and of the recorded BOM index.
    localparam int INDEX_BITS = 24;

    localparam int BYTE_W     = 8;
    localparam int SCALAR_W   = 21;
    localparam int STATUS_W   = 2;
    localparam int POS_W      = 24;
    localparam int OUT_BITS   = SCALAR_W + STATUS_W + 1 + POS_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;
    localparam int CMP_W      = (INDEX_BITS > POS_W) ? INDEX_BITS : POS_W;

    localparam logic [INDEX_BITS-1:0] CNT_MAX = '1;
    localparam logic [POS_W-1:0]      POS_MAX = '1;

    // Byte classes.
    localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD2_TAG  = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD3_TAG  = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
    localparam logic [BYTE_W-1:0] LEAD4_TAG  = 8'hF0;
    localparam logic [BYTE_W-1:0] CONT_MASK  = 8'hC0;
    localparam logic [BYTE_W-1:0] CONT_TAG   = 8'h80;

    // Code point limits and special scalars.
    localparam logic [SCALAR_W-1:0] CP_MIN2  = 21'h00080;
    localparam logic [SCALAR_W-1:0] CP_MIN3  = 21'h00800;
    localparam logic [SCALAR_W-1:0] CP_MIN4  = 21'h10000;
    localparam logic [SCALAR_W-1:0] CP_MAX   = 21'h10FFFF;
    localparam logic [SCALAR_W-1:0] SURR_LO  = 21'h0D800;
    localparam logic [SCALAR_W-1:0] SURR_HI  = 21'h0DFFF;
    localparam logic [SCALAR_W-1:0] BOM_CODE = 21'h0FEFF;
    localparam logic [SCALAR_W-1:0] CR_CODE  = 21'h0000D;
    localparam logic [SCALAR_W-1:0] LF_CODE  = 21'h0000A;

    // Sequence length codes; a four-byte sequence is coded as zero.
    localparam logic [1:0] SEQ_LEN2 = 2'd2;
    localparam logic [1:0] SEQ_LEN3 = 2'd3;
    localparam logic [1:0] SEQ_LEN4 = 2'd0;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 2'd0,
        ST_DECODE_ERR   = 2'd1,
        ST_EMBEDDED_BOM = 2'd2
    } t_status;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              has_byte;
        logic              end_of_file;
    } t_item;

    typedef struct packed {
        logic [SCALAR_W-1:0] scalar;
        logic                scalar_valid;
        logic                end_of_stream;
        t_status             status;
        logic                had_lead_bom;
        logic [POS_W-1:0]    bom_position;
    } t_result;

endpackage

FILE: hw/rtl/u8dn_core.sv
// Decode state and the per-byte step. The state advances when i_step is high.
module u8dn_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  u8dn_pkg::t_item   i_item,
    output logic              o_has_result,
    output u8dn_pkg::t_result o_result
);

    logic [1:0]                          r_pend, n_pend;
    logic [1:0]                          r_len, n_len;
    logic [u8dn_pkg::SCALAR_W-1:0]       r_acc, n_acc;
    logic                                r_first, n_first;
    logic                                r_prev_cr, n_prev_cr;
    logic                                r_lead, n_lead;
    logic                                r_failed, n_failed;
    logic                                r_found, n_found;
    logic [u8dn_pkg::INDEX_BITS-1:0]     r_idx, n_idx;
    logic [u8dn_pkg::INDEX_BITS-1:0]     r_cnt, n_cnt;

    logic [u8dn_pkg::BYTE_W-1:0]         w_b;
    logic [u8dn_pkg::SCALAR_W-1:0]       w_acc_shift;
    logic [1:0]                          w_pend_dec;
    logic                                w_bad;
    logic                                w_err;
    logic                                w_cplt;
    logic [u8dn_pkg::SCALAR_W-1:0]       w_u;
    logic                                w_emit;
    logic [u8dn_pkg::SCALAR_W-1:0]       w_sc;
    logic                                w_fail_end;
    u8dn_pkg::t_status                   w_status;
    logic [u8dn_pkg::CMP_W-1:0]          w_idx_ext;

    assign w_b         = i_item.data_byte;
    assign w_acc_shift = {r_acc[u8dn_pkg::SCALAR_W-7:0], w_b[5:0]};
    assign w_pend_dec  = r_pend - 2'd1;

    always_comb begin
        n_pend    = r_pend;
        n_len     = r_len;
        n_acc     = r_acc;
        n_first   = r_first;
        n_prev_cr = r_prev_cr;
        n_lead    = r_lead;
        n_failed  = r_failed;
        n_found   = r_found;
        n_idx     = r_idx;
        n_cnt     = r_cnt;
        w_bad     = 1'b0;
        w_err     = 1'b0;
        w_cplt    = 1'b0;
        w_u       = '0;
        w_emit    = 1'b0;
        w_sc      = '0;
        w_fail_end = 1'b0;
        w_status  = u8dn_pkg::ST_OK;
        w_idx_ext = '0;
        o_result  = '0;

        // Byte decode.
        if (i_item.has_byte && !r_failed) begin
            if (r_pend == 2'd0) begin
                if (!w_b[7]) begin
                    w_cplt = 1'b1;
                    w_u    = u8dn_pkg::SCALAR_W'(w_b);
                end else if ((w_b & u8dn_pkg::LEAD2_MASK) == u8dn_pkg::LEAD2_TAG) begin
                    n_acc  = u8dn_pkg::SCALAR_W'(w_b[4:0]);
                    n_pend = 2'd1;
                    n_len  = u8dn_pkg::SEQ_LEN2;
                end else if ((w_b & u8dn_pkg::LEAD3_MASK) == u8dn_pkg::LEAD3_TAG) begin
                    n_acc  = u8dn_pkg::SCALAR_W'(w_b[3:0]);
                    n_pend = 2'd2;
                    n_len  = u8dn_pkg::SEQ_LEN3;
                end else if ((w_b & u8dn_pkg::LEAD4_MASK) == u8dn_pkg::LEAD4_TAG) begin
                    n_acc  = u8dn_pkg::SCALAR_W'(w_b[2:0]);
                    n_pend = 2'd3;
                    n_len  = u8dn_pkg::SEQ_LEN4;
                end else begin
                    w_err = 1'b1;
                end
            end else if ((w_b & u8dn_pkg::CONT_MASK) != u8dn_pkg::CONT_TAG) begin
                w_err = 1'b1;
            end else begin
                n_acc  = w_acc_shift;
                n_pend = w_pend_dec;
                if (w_pend_dec == 2'd0) begin
                    case (r_len)
                        u8dn_pkg::SEQ_LEN2: begin
                            w_bad = w_acc_shift < u8dn_pkg::CP_MIN2;
                        end
                        u8dn_pkg::SEQ_LEN3: begin
                            w_bad = (w_acc_shift < u8dn_pkg::CP_MIN3) ||
                                    ((w_acc_shift >= u8dn_pkg::SURR_LO) &&
                                     (w_acc_shift <= u8dn_pkg::SURR_HI));
                        end
                        default: begin
                            w_bad = (w_acc_shift < u8dn_pkg::CP_MIN4) ||
                                    (w_acc_shift > u8dn_pkg::CP_MAX);
                        end
                    endcase
                    n_acc = '0;
                    n_len = '0;
                    if (w_bad) begin
                        w_err = 1'b1;
                    end else begin
                        w_cplt = 1'b1;
                        w_u    = w_acc_shift;
                    end
                end
            end
        end

        if (w_err) begin
            n_failed = 1'b1;
            n_pend   = '0;
            n_len    = '0;
            n_acc    = '0;
        end

        // Scalar handling: leading BOM strip, BOM index, newline folding.
        if (w_cplt) begin
            n_first = 1'b0;
            if (r_first && (w_u == u8dn_pkg::BOM_CODE)) begin
                n_lead = 1'b1;
            end else begin
                if ((w_u == u8dn_pkg::BOM_CODE) && !r_found) begin
                    n_found = 1'b1;
                    n_idx   = r_cnt;
                end
                if (r_cnt != u8dn_pkg::CNT_MAX) begin
                    n_cnt = r_cnt + 1'b1;
                end
                if (r_prev_cr && (w_u == u8dn_pkg::LF_CODE)) begin
                    n_prev_cr = 1'b0;
                end else if (w_u == u8dn_pkg::CR_CODE) begin
                    n_prev_cr = 1'b1;
                    w_emit    = 1'b1;
                    w_sc      = u8dn_pkg::LF_CODE;
                end else begin
                    n_prev_cr = 1'b0;
                    w_emit    = 1'b1;
                    w_sc      = w_u;
                end
            end
        end

        o_result.scalar       = w_sc;
        o_result.scalar_valid = w_emit;

        // End of file: report status, then return to the reset state.
        if (i_item.end_of_file) begin
            w_fail_end = n_failed || (n_pend != 2'd0);
            if (w_fail_end) begin
                w_status = u8dn_pkg::ST_DECODE_ERR;
            end else if (n_found) begin
                w_status = u8dn_pkg::ST_EMBEDDED_BOM;
            end else begin
                w_status = u8dn_pkg::ST_OK;
            end
            w_idx_ext = u8dn_pkg::CMP_W'(n_idx);
            o_result.end_of_stream = 1'b1;
            o_result.status        = w_status;
            o_result.had_lead_bom  = !w_fail_end && n_lead;
            if (w_status == u8dn_pkg::ST_EMBEDDED_BOM) begin
                o_result.bom_position =
                    (w_idx_ext > u8dn_pkg::CMP_W'(u8dn_pkg::POS_MAX)) ?
                    u8dn_pkg::POS_MAX : u8dn_pkg::POS_W'(w_idx_ext);
            end
            n_pend    = '0;
            n_len     = '0;
            n_acc     = '0;
            n_first   = 1'b1;
            n_prev_cr = 1'b0;
            n_lead    = 1'b0;
            n_failed  = 1'b0;
            n_found   = 1'b0;
            n_idx     = '0;
            n_cnt     = '0;
        end
    end

    assign o_has_result = w_emit || i_item.end_of_file;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend    <= '0;
            r_len     <= '0;
            r_acc     <= '0;
            r_first   <= 1'b1;
            r_prev_cr <= 1'b0;
            r_lead    <= 1'b0;
            r_failed  <= 1'b0;
            r_found   <= 1'b0;
            r_idx     <= '0;
            r_cnt     <= '0;
        end else if (i_step) begin
            r_pend    <= n_pend;
            r_len     <= n_len;
            r_acc     <= n_acc;
            r_first   <= n_first;
            r_prev_cr <= n_prev_cr;
            r_lead    <= n_lead;
            r_failed  <= n_failed;
            r_found   <= n_found;
            r_idx     <= n_idx;
            r_cnt     <= n_cnt;
        end
    end

endmodule

FILE: hw/rtl/utf8_decode_bom_newline_normalize_top.sv
// Channel   Dir  Word fields (lowest bit first)
// s_axis    in   tdata: data_byte[7:0]; tuser: has_byte; tlast: end_of_file
// m_axis    out  tdata: scalar[20:0], status[22:21], had_lead_bom[23],
//                bom_position[47:24]; tuser: scalar_valid; tlast: end_of_stream
//
// One word can be accepted in every cycle while the output is not stalled. An
// accepted word is held in the input register and decoded there; once the output
// register has room, its result (if any) is loaded into the output register and
// m_axis_tvalid rises.
// Reset is synchronous and active low; it clears all decode state and empties
// both registers. When the output register is full and not taken, the input
// register holds its word and s_axis_tready drops once it is occupied.
module utf8_decode_bom_newline_normalize_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [u8dn_pkg::BYTE_W-1:0]       s_axis_tdata,  // data_byte
    input  logic                              s_axis_tuser,  // has_byte
    input  logic                              s_axis_tlast,  // end_of_file
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // scalar, status, had_lead_bom, bom_position
    output logic [u8dn_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    output logic                              m_axis_tuser,  // scalar_valid
    output logic                              m_axis_tlast   // end_of_stream
);

    // Input register.
    logic              r_in_valid;
    u8dn_pkg::t_item   r_in;

    // Output register.
    logic              r_out_valid;
    u8dn_pkg::t_result r_out;

    logic              w_step;
    logic              w_has_result;
    u8dn_pkg::t_result w_result;

    // The held word moves on whenever the output register has room.
    assign w_step        = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_step;

    u8dn_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (w_step),
        .i_item       (r_in),
        .o_has_result (w_has_result),
        .o_result     (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (w_step) begin
                r_out_valid <= w_has_result;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in.data_byte   <= s_axis_tdata;
            r_in.has_byte    <= s_axis_tuser;
            r_in.end_of_file <= s_axis_tlast;
        end
        if (w_step && w_has_result) begin
            r_out <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = u8dn_pkg::OUT_DATA_W'({r_out.bom_position, r_out.had_lead_bom,
                                                  r_out.status, r_out.scalar});
    assign m_axis_tuser  = r_out.scalar_valid;
    assign m_axis_tlast  = r_out.end_of_stream;

    // A status other than ok is only reported on the final word of a file.
    a_status_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tdata[22:21] == 2'd0))
        else $error("status set on a word that is not the last");

    // Every word produced carries either a scalar or the end of the stream.
    a_no_empty_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser || m_axis_tlast))
        else $error("output word carries neither a scalar nor end of stream");

    // A stripped leading BOM is never reported together with a decode error.
    a_lead_bom_not_with_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[23]) |-> (m_axis_tdata[22:21] != 2'd1))
        else $error("leading BOM flagged on a failed decode");

    // A held word stalled by a full output register keeps the input side closed.
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input accepted while the pipeline is stalled");

endmodule

FILE: tb/utf8_decode_bom_newline_normalize_top_tb.sv
module utf8_decode_bom_newline_normalize_top_tb;

    // Clock, reset and the two stream channels. Every input of the block
    // starts at a known value.
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [u8dn_pkg::BYTE_W-1:0]     s_axis_tdata = '0;   // data_byte
    logic                            s_axis_tuser = 1'b0; // has_byte
    logic                            s_axis_tlast = 1'b0; // end_of_file
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    // scalar, status, had_lead_bom, bom_position (lowest bit first)
    logic [u8dn_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic                            m_axis_tuser;        // scalar_valid
    logic                            m_axis_tlast;        // end_of_stream

    utf8_decode_bom_newline_normalize_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Words waiting to be sent, the file under construction, and the decoded
    // results that the block still owes us, oldest first.
    u8dn_pkg::t_item   bytes_to_send[$];
    u8dn_pkg::t_item   file_q[$];
    u8dn_pkg::t_result scalars_due[$];

    int mismatches = 0;
    int sent_bytes = 0;
    bit calm = 1'b0;        // when set, neither side inserts gaps
    bit word_taken = 1'b0;  // set by the monitor when an input word is accepted
    int send_wait = 0;
    int ready_wait = 0;

    // Decoder state as the predictor sees it. The sequence length code uses
    // zero for a four-byte sequence, just like the block.
    logic [1:0]                      need_conts;
    logic [1:0]                      seq_code;
    logic [u8dn_pkg::SCALAR_W-1:0]   cp_acc;
    bit                              first_pending;
    bit                              after_cr;
    bit                              lead_bom_dropped;
    bit                              bad_input;
    bit                              mid_bom_hit;
    logic [u8dn_pkg::INDEX_BITS-1:0] mid_bom_at;
    logic [u8dn_pkg::INDEX_BITS-1:0] scalars_seen;

    task automatic clear_decoder();
        need_conts       = '0;
        seq_code         = '0;
        cp_acc           = '0;
        first_pending    = 1'b1;
        after_cr         = 1'b0;
        lead_bom_dropped = 1'b0;
        bad_input        = 1'b0;
        mid_bom_hit      = 1'b0;
        mid_bom_at       = '0;
        scalars_seen     = '0;
    endtask

    // Once the input is known to be malformed, the rest of the file is ignored.
    task automatic abandon_decode();
        bad_input  = 1'b1;
        need_conts = '0;
        seq_code   = '0;
        cp_acc     = '0;
    endtask

    // Works out the result, if any, that one accepted word produces.
    task automatic decode_utf8_word(input u8dn_pkg::t_item w, output bit made,
                                    output u8dn_pkg::t_result res);
        logic [u8dn_pkg::SCALAR_W-1:0] cp;
        logic [u8dn_pkg::SCALAR_W-1:0] emitted;
        bit                            done;
        bit                            emit;
        bit                            bad;
        u8dn_pkg::t_status             st;
        res     = '0;
        made    = 1'b0;
        done    = 1'b0;
        emit    = 1'b0;
        bad     = 1'b0;
        cp      = '0;
        emitted = '0;

        if (w.has_byte && !bad_input) begin
            if (need_conts == 0) begin
                if (!w.data_byte[u8dn_pkg::BYTE_W-1]) begin
                    cp   = u8dn_pkg::SCALAR_W'(w.data_byte);
                    done = 1'b1;
                end else if ((w.data_byte & u8dn_pkg::LEAD2_MASK) == u8dn_pkg::LEAD2_TAG) begin
                    cp_acc     = u8dn_pkg::SCALAR_W'(w.data_byte & ~u8dn_pkg::LEAD2_MASK);
                    need_conts = 2'd1;
                    seq_code   = u8dn_pkg::SEQ_LEN2;
                end else if ((w.data_byte & u8dn_pkg::LEAD3_MASK) == u8dn_pkg::LEAD3_TAG) begin
                    cp_acc     = u8dn_pkg::SCALAR_W'(w.data_byte & ~u8dn_pkg::LEAD3_MASK);
                    need_conts = 2'd2;
                    seq_code   = u8dn_pkg::SEQ_LEN3;
                end else if ((w.data_byte & u8dn_pkg::LEAD4_MASK) == u8dn_pkg::LEAD4_TAG) begin
                    cp_acc     = u8dn_pkg::SCALAR_W'(w.data_byte & ~u8dn_pkg::LEAD4_MASK);
                    need_conts = 2'd3;
                    seq_code   = u8dn_pkg::SEQ_LEN4;
                end else begin
                    abandon_decode();
                end
            end else if ((w.data_byte & u8dn_pkg::CONT_MASK) != u8dn_pkg::CONT_TAG) begin
                abandon_decode();
            end else begin
                cp_acc     = {cp_acc[u8dn_pkg::SCALAR_W-7:0], w.data_byte[5:0]};
                need_conts = need_conts - 2'd1;
                if (need_conts == 0) begin
                    case (seq_code)
                        u8dn_pkg::SEQ_LEN2: bad = cp_acc < u8dn_pkg::CP_MIN2;
                        u8dn_pkg::SEQ_LEN3: bad = cp_acc < u8dn_pkg::CP_MIN3 ||
                                                  (cp_acc >= u8dn_pkg::SURR_LO &&
                                                   cp_acc <= u8dn_pkg::SURR_HI);
                        default:  bad = cp_acc < u8dn_pkg::CP_MIN4 ||
                                        cp_acc > u8dn_pkg::CP_MAX;
                    endcase
                    cp       = cp_acc;
                    cp_acc   = '0;
                    seq_code = '0;
                    if (bad) begin
                        abandon_decode();
                    end else begin
                        done = 1'b1;
                    end
                end
            end
        end

        if (done) begin
            // A mark in first position vanishes without being counted.
            if (first_pending) begin
                first_pending = 1'b0;
                if (cp == u8dn_pkg::BOM_CODE) begin
                    lead_bom_dropped = 1'b1;
                    done = 1'b0;
                end
            end
        end
        if (done) begin
            if (cp == u8dn_pkg::BOM_CODE && !mid_bom_hit) begin
                mid_bom_hit = 1'b1;
                mid_bom_at  = scalars_seen;
            end
            if (scalars_seen != u8dn_pkg::CNT_MAX) begin
                scalars_seen = scalars_seen + 1'b1;
            end
            if (after_cr && cp == u8dn_pkg::LF_CODE) begin
                after_cr = 1'b0;
            end else if (cp == u8dn_pkg::CR_CODE) begin
                after_cr = 1'b1;
                emit     = 1'b1;
                emitted  = u8dn_pkg::LF_CODE;
            end else begin
                after_cr = 1'b0;
                emit     = 1'b1;
                emitted  = cp;
            end
        end

        if (emit || w.end_of_file) begin
            made             = 1'b1;
            res.scalar       = emit ? emitted : '0;
            res.scalar_valid = emit;
            res.status       = u8dn_pkg::ST_OK;
            if (w.end_of_file) begin
                if (need_conts != 0) begin
                    abandon_decode();
                end
                if (bad_input) begin
                    st = u8dn_pkg::ST_DECODE_ERR;
                end else if (mid_bom_hit) begin
                    st = u8dn_pkg::ST_EMBEDDED_BOM;
                end else begin
                    st = u8dn_pkg::ST_OK;
                end
                res.end_of_stream = 1'b1;
                res.status        = st;
                res.had_lead_bom  = (st != u8dn_pkg::ST_DECODE_ERR) && lead_bom_dropped;
                if (st == u8dn_pkg::ST_EMBEDDED_BOM) begin
                    if (u8dn_pkg::CMP_W'(mid_bom_at) >
                        u8dn_pkg::CMP_W'(u8dn_pkg::POS_MAX)) begin
                        res.bom_position = u8dn_pkg::POS_MAX;
                    end else begin
                        res.bom_position = u8dn_pkg::POS_W'(mid_bom_at);
                    end
                end
                clear_decoder();
            end
        end
    endtask

    // Gap lengths: usually none, often a few cycles, now and then a long one.
    function automatic int pick_pause();
        int r;
        if (calm) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 30);
    endfunction

    function automatic void check_field(string name, logic [u8dn_pkg::POS_W-1:0] want,
                                        logic [u8dn_pkg::POS_W-1:0] seen);
        if (want !== seen) begin
            mismatches++;
            $display("%0t: %s expected %h, got %h", $time, name, want, seen);
        end
    endfunction

    // Stimulus building blocks. A file is assembled in file_q and then handed
    // to the driver as a whole.
    task automatic put_byte(input logic [u8dn_pkg::BYTE_W-1:0] b);
        u8dn_pkg::t_item w;
        w.data_byte   = b;
        w.has_byte    = 1'b1;
        w.end_of_file = 1'b0;
        file_q.insert(file_q.size(), w);
        sent_bytes++;
    endtask

    task automatic put_idle();
        u8dn_pkg::t_item w;
        w.data_byte   = u8dn_pkg::BYTE_W'($urandom);
        w.has_byte    = 1'b0;
        w.end_of_file = 1'b0;
        file_q.insert(file_q.size(), w);
    endtask

    // Encodes cp with the given number of bytes. A length longer than needed
    // gives an overlong form, and nothing stops surrogates or values past the
    // top of the code space.
    task automatic put_code(input int unsigned cp, input int len);
        case (len)
            1: put_byte(cp[7:0]);
            2: begin
                put_byte(u8dn_pkg::LEAD2_TAG | u8dn_pkg::BYTE_W'(cp[10:6]));
                put_byte(u8dn_pkg::CONT_TAG | u8dn_pkg::BYTE_W'(cp[5:0]));
            end
            3: begin
                put_byte(u8dn_pkg::LEAD3_TAG | u8dn_pkg::BYTE_W'(cp[15:12]));
                put_byte(u8dn_pkg::CONT_TAG | u8dn_pkg::BYTE_W'(cp[11:6]));
                put_byte(u8dn_pkg::CONT_TAG | u8dn_pkg::BYTE_W'(cp[5:0]));
            end
            default: begin
                put_byte(u8dn_pkg::LEAD4_TAG | u8dn_pkg::BYTE_W'(cp[20:18]));
                put_byte(u8dn_pkg::CONT_TAG | u8dn_pkg::BYTE_W'(cp[17:12]));
                put_byte(u8dn_pkg::CONT_TAG | u8dn_pkg::BYTE_W'(cp[11:6]));
                put_byte(u8dn_pkg::CONT_TAG | u8dn_pkg::BYTE_W'(cp[5:0]));
            end
        endcase
    endtask

    // A lead byte followed by too few continuation bytes.
    task automatic put_cut_sequence();
        int len;
        len = $urandom_range(2, 4);
        case (len)
            2: put_byte(u8dn_pkg::LEAD2_TAG |
                        (~u8dn_pkg::LEAD2_MASK & u8dn_pkg::BYTE_W'($urandom)));
            3: put_byte(u8dn_pkg::LEAD3_TAG |
                        (~u8dn_pkg::LEAD3_MASK & u8dn_pkg::BYTE_W'($urandom)));
            default: put_byte(u8dn_pkg::LEAD4_TAG |
                              (~u8dn_pkg::LEAD4_MASK & u8dn_pkg::BYTE_W'($urandom)));
        endcase
        repeat ($urandom_range(0, len - 2)) begin
            put_byte(u8dn_pkg::CONT_TAG | (~u8dn_pkg::CONT_MASK & u8dn_pkg::BYTE_W'($urandom)));
        end
    endtask

    // Closes the file, either on its last byte or with a word that has none.
    task automatic ship_file(input bit lone_end);
        u8dn_pkg::t_item w;
        if (lone_end || file_q.size() == 0) begin
            w.data_byte = u8dn_pkg::BYTE_W'($urandom);
            w.has_byte  = 1'b0;
        end else begin
            w = file_q.pop_back();
        end
        w.end_of_file = 1'b1;
        file_q.insert(file_q.size(), w);
        while (file_q.size() != 0) begin
            bytes_to_send.insert(bytes_to_send.size(), file_q.pop_front());
        end
    endtask

    task automatic put_random_chunk(input bit flawed);
        int unsigned cp;
        int          r;
        r = $urandom_range(0, 99);
        if (r < 28) begin
            put_code($urandom_range(0, 'h7F), 1);
        end else if (r < 38) begin
            put_code(u8dn_pkg::CR_CODE, 1);
            put_code($urandom_range(0, 1) ? u8dn_pkg::LF_CODE : u8dn_pkg::CR_CODE, 1);
        end else if (r < 50) begin
            put_code($urandom_range(u8dn_pkg::CP_MIN2, u8dn_pkg::CP_MIN3 - 1), 2);
        end else if (r < 62) begin
            cp = $urandom_range(u8dn_pkg::CP_MIN3, u8dn_pkg::CP_MIN4 - 1);
            if (cp >= u8dn_pkg::SURR_LO && cp <= u8dn_pkg::SURR_HI) begin
                cp = cp + 'h2000;
            end
            put_code(cp, 3);
        end else if (r < 72) begin
            put_code($urandom_range(u8dn_pkg::CP_MIN4, u8dn_pkg::CP_MAX), 4);
        end else if (r < 76) begin
            put_code(u8dn_pkg::BOM_CODE, 3);
        end else if (r < 80) begin
            put_idle();
        end else if (!flawed) begin
            put_code($urandom_range(0, 'h7F), 1);
        end else begin
            case ($urandom_range(0, 8))
                0: put_code($urandom_range(0, u8dn_pkg::CP_MIN2 - 1), 2);
                1: put_code($urandom_range(0, u8dn_pkg::CP_MIN3 - 1), 3);
                2: put_code($urandom_range(0, u8dn_pkg::CP_MIN4 - 1), 4);
                3: put_code($urandom_range(u8dn_pkg::SURR_LO, u8dn_pkg::SURR_HI), 3);
                4: put_code($urandom_range(u8dn_pkg::CP_MAX + 1, 'h1FFFFF), 4);
                5: put_byte(u8dn_pkg::CONT_TAG |
                            (~u8dn_pkg::CONT_MASK & u8dn_pkg::BYTE_W'($urandom)));
                6: put_byte(u8dn_pkg::BYTE_W'($urandom_range(u8dn_pkg::LEAD4_MASK, 'hFF)));
                7: begin
                    put_cut_sequence();
                    put_code($urandom_range(0, 'h7F), 1);
                end
                default: put_byte(u8dn_pkg::BYTE_W'($urandom));
            endcase
        end
    endtask

    // Most files are clean; about one in four may hold malformed input. A few
    // files are long so that scalar indexes grow past a handful.
    task automatic build_random_file();
        bit flawed;
        int chunks;
        flawed = ($urandom_range(0, 3) == 0);
        chunks = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 10);
        if ($urandom_range(0, 2) == 0) begin
            put_code(u8dn_pkg::BOM_CODE, 3);
        end
        repeat (chunks) begin
            put_random_chunk(flawed);
        end
        if (flawed && $urandom_range(0, 4) == 0) begin
            put_cut_sequence();
        end
        ship_file($urandom_range(0, 2) == 0);
    endtask

    // Returns once every queued word has been taken and every result is in.
    // Sampling at the rising edge keeps this clear of the driver's updates.
    task automatic wait_drained();
        while (bytes_to_send.size() != 0 || s_axis_tvalid || scalars_due.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Driver: presents queued words and the receiver's ready at the falling
    // edge. A word stays up until the monitor reports that it was taken.
    always @(negedge i_clk) begin
        u8dn_pkg::t_item w;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            m_axis_tready <= 1'b0;
        end else begin
            if (!s_axis_tvalid || word_taken) begin
                word_taken = 1'b0;
                if (send_wait > 0) begin
                    send_wait--;
                    s_axis_tvalid <= 1'b0;
                end else if (bytes_to_send.size() != 0) begin
                    w = bytes_to_send.pop_front();
                    s_axis_tdata  <= w.data_byte;
                    s_axis_tuser  <= w.has_byte;
                    s_axis_tlast  <= w.end_of_file;
                    s_axis_tvalid <= 1'b1;
                    send_wait = pick_pause();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
            if (ready_wait > 0) begin
                ready_wait--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                ready_wait = pick_pause();
            end
        end
    end

    // Monitor: at each rising edge, predicts the result of an accepted input
    // word and checks an accepted output word against the oldest prediction.
    always @(posedge i_clk) begin
        u8dn_pkg::t_item   w;
        u8dn_pkg::t_result want;
        u8dn_pkg::t_result seen;
        bit                made;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            w.data_byte   = s_axis_tdata;
            w.has_byte    = s_axis_tuser;
            w.end_of_file = s_axis_tlast;
            decode_utf8_word(w, made, want);
            if (made) begin
                scalars_due.insert(scalars_due.size(), want);
            end
            word_taken = 1'b1;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen.scalar        = m_axis_tdata[u8dn_pkg::SCALAR_W-1:0];
            seen.status        = u8dn_pkg::t_status'(
                                     m_axis_tdata[u8dn_pkg::SCALAR_W +: u8dn_pkg::STATUS_W]);
            seen.had_lead_bom  = m_axis_tdata[u8dn_pkg::SCALAR_W + u8dn_pkg::STATUS_W];
            seen.bom_position  = m_axis_tdata[u8dn_pkg::SCALAR_W + u8dn_pkg::STATUS_W + 1 +:
                                              u8dn_pkg::POS_W];
            seen.scalar_valid  = m_axis_tuser;
            seen.end_of_stream = m_axis_tlast;
            if (scalars_due.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, expected none, got %h", $time, seen);
            end else begin
                want = scalars_due.pop_front();
                check_field("scalar", u8dn_pkg::POS_W'(want.scalar),
                            u8dn_pkg::POS_W'(seen.scalar));
                check_field("scalar_valid", u8dn_pkg::POS_W'(want.scalar_valid),
                            u8dn_pkg::POS_W'(seen.scalar_valid));
                check_field("end_of_stream", u8dn_pkg::POS_W'(want.end_of_stream),
                            u8dn_pkg::POS_W'(seen.end_of_stream));
                check_field("status", u8dn_pkg::POS_W'(want.status),
                            u8dn_pkg::POS_W'(seen.status));
                check_field("had_lead_bom", u8dn_pkg::POS_W'(want.had_lead_bom),
                            u8dn_pkg::POS_W'(seen.had_lead_bom));
                check_field("bom_position", want.bom_position, seen.bom_position);
            end
        end
    end

    // Main sequence: reset, a directed set of files, then random files in
    // batches. Each batch either runs with no gaps at all or with random gaps,
    // and some batches end with the sender holding off until every result
    // has come back.
    initial begin
        clear_decoder();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Leading mark dropped, CR LF, an idle word, lone CR, the largest one-byte
        // scalar, an embedded mark, the smallest two-byte scalar, a zero byte, and the
        // largest scalar completed by the end-of-file word itself.
        put_code(u8dn_pkg::BOM_CODE, 3);
        put_code(u8dn_pkg::CR_CODE, 1);
        put_code(u8dn_pkg::LF_CODE, 1);
        put_idle();
        put_code(u8dn_pkg::CR_CODE, 1);
        put_code('h7F, 1);
        put_code(u8dn_pkg::BOM_CODE, 3);
        put_code(u8dn_pkg::CP_MIN2, 2);
        put_code(0, 1);
        put_code(u8dn_pkg::CP_MAX, 4);
        ship_file(1'b0);
        // An empty file: the end word carries no byte.
        ship_file(1'b1);
        // The LF of a CR LF pair arrives on the end word and is swallowed.
        put_code(u8dn_pkg::CR_CODE, 1);
        put_code(u8dn_pkg::LF_CODE, 1);
        ship_file(1'b0);
        // A stray continuation byte, then a byte that must be ignored.
        put_byte(u8dn_pkg::CONT_TAG);
        put_byte(8'h41);
        ship_file(1'b1);
        // A three-byte sequence cut short by the end of the file.
        put_byte(u8dn_pkg::LEAD3_TAG | 8'h02);
        put_byte(u8dn_pkg::CONT_TAG | 8'h02);
        ship_file(1'b0);
        wait_drained();

        while (sent_bytes < 1000) begin
            calm = ($urandom_range(0, 4) == 0);
            repeat ($urandom_range(2, 6)) begin
                build_random_file();
            end
            if ($urandom_range(0, 5) == 0) begin
                wait_drained();
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end else begin
                while (bytes_to_send.size() > 8) @(posedge i_clk);
            end
        end

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("utf8_decode_bom_newline_normalize_top_tb: clean");
        end else begin
            $display("utf8_decode_bom_newline_normalize_top_tb: errors");
        end
        $finish;
    end

    // Watchdog for a block that stops answering.
    initial begin
        #5000000;
        $display("utf8_decode_bom_newline_normalize_top_tb: errors");
        $finish;
    end

endmodule

FILE: utf8_decode_bom_newline_normalize_top.f
hw/rtl/u8dn_pkg.sv
hw/rtl/u8dn_core.sv
hw/rtl/utf8_decode_bom_newline_normalize_top.sv
tb/utf8_decode_bom_newline_normalize_top_tb.sv
